// ===== src/pov_column_timing_controller_defines.svh =====
// Assertion macros shared by the column timing controller RTL.
// Needs clk and rst_n in the scope where a macro is used; no other dependencies.
`ifndef POV_COLUMN_TIMING_CONTROLLER_DEFINES_SVH
`define POV_COLUMN_TIMING_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define PCTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define PCTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PCTC_ASSERT_SAME(label, ante, cons)
`define PCTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/pctc_pkg.sv =====
// Package for the column timing controller: field widths, mode codes and the
// built-in picture. No dependencies.
package pctc_pkg;

    localparam int COLUMNS_DEFAULT     = 64;
    localparam int TIMER_WIDTH_DEFAULT = 16;

    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 6;
    localparam int BITS_W  = 8;
    localparam int SHOWN_W = 7;
    localparam int STEP_W  = 16;

    localparam int PICTURE_LEN = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_HALL = 2'd1,
        MODE_LOAD = 2'd2
    } mode_t;

    localparam logic [BITS_W-1:0] PICTURE [PICTURE_LEN] = '{
        8'hff, 8'h13, 8'h13, 8'h13, 8'h13, 8'h01,
        8'h83, 8'h83, 8'hff, 8'h83, 8'h83, 8'h01,
        8'h7d, 8'h83, 8'h93, 8'h93, 8'h75, 8'h01,
        8'hff, 8'h11, 8'h11, 8'h11, 8'hff, 8'h01,
        8'h03, 8'h03, 8'hff, 8'h03, 8'h03, 8'h01,
        8'hff, 8'h93, 8'h93, 8'h93, 8'h93, 8'h01,
        8'hff, 8'h13, 8'h33, 8'h53, 8'h8d, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h01, 8'h01, 8'h01, 8'h01
    };

    // Power-up contents of a column; columns past the picture start dark.
    function automatic logic [BITS_W-1:0] picture_column(input logic [7:0] idx);
        logic [BITS_W-1:0] val;
        val = 8'h00;
        if (idx < 8'(PICTURE_LEN))
        begin
            val = PICTURE[idx[5:0]];
        end
        return val;
    endfunction

endpackage

// ===== src/pctc_in_if.sv =====
// Input channel of the column timing controller: valid, ready and one item.
// Depends on pctc_pkg.
interface pctc_in_if;
    import pctc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] column_address;
    logic [BITS_W-1:0] column_bits;

    modport source (output valid, output mode, output column_address,
                    output column_bits, input ready);
    modport sink (input valid, input mode, input column_address,
                  input column_bits, output ready);
endinterface

// ===== src/pctc_out_if.sv =====
// Result channel of the column timing controller: valid, ready and one result.
// Depends on pctc_pkg.
interface pctc_out_if;
    import pctc_pkg::*;

    logic               valid;
    logic               ready;
    logic [BITS_W-1:0]  led_drive;
    logic               column_strobe;
    logic [SHOWN_W-1:0] column_shown;

    modport source (output valid, output led_drive, output column_strobe,
                    output column_shown, input ready);
    modport sink (input valid, input led_drive, input column_strobe,
                  input column_shown, output ready);
endinterface

// ===== src/pov_column_timing_controller.sv =====
// Column timer for a rotating LED display: one item is taken every clock cycle
// and its result is held in an output register, set at the accepting edge; a full output
// with a stalled sink blocks input. The column step is built during the
// revolution by a divide-by-COLUMNS prescaler, and the pattern RAM is read
// ahead at the next column, so no path holds more than one timer add and
// compare. Columns never written read as the built-in picture; no clearing pass.
// Depends on pctc_pkg, pctc_in_if, pctc_out_if, pctc_ram and the defines header.
`include "pov_column_timing_controller_defines.svh"

module pov_column_timing_controller #(
    parameter int COLUMNS     = pctc_pkg::COLUMNS_DEFAULT,
    parameter int TIMER_WIDTH = pctc_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    pctc_in_if.sink     item,
    pctc_out_if.source  result
);
    import pctc_pkg::*;

    localparam int AW  = $clog2(COLUMNS);
    localparam int CIW = $clog2(COLUMNS + 1);
    localparam int SW  = $clog2(COLUMNS);
    localparam int TW  = TIMER_WIDTH;

    logic [TW-1:0]      tick_reg, tick_next;
    logic [TW-1:0]      cmp_reg, cmp_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [SW-1:0]      sub_reg, sub_next;
    logic [STEP_W-1:0]  quot_reg, quot_next;
    logic [CIW-1:0]     col_idx_reg, col_idx_next;
    logic [BITS_W-1:0]  led_reg, led_next;
    logic               strobe_reg, strobe_next;
    logic               out_valid_reg, out_valid_next;
    logic [COLUMNS-1:0] col_valid_reg;
    logic               wr_last_reg;
    logic [AW-1:0]      wr_addr_last_reg;
    logic [BITS_W-1:0]  wr_data_last_reg;

    logic              accept;
    logic              wr_en;
    logic              addr_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     col_addr;
    logic              col_lt;
    logic [BITS_W-1:0] ram_rd;
    logic [BITS_W-1:0] pattern;
    logic              match;
    logic              hall_acc;

    assign accept   = item.valid && item.ready;
    assign hall_acc = accept && (item.mode == MODE_HALL);
    assign addr_ok  = int'(item.column_address) < COLUMNS;
    assign wr_addr  = AW'(item.column_address);
    assign wr_en    = accept && (item.mode == MODE_LOAD) && addr_ok;
    assign col_addr = col_idx_reg[AW-1:0];
    assign col_lt   = col_idx_reg < CIW'(COLUMNS);

    pctc_ram #(
        .WIDTH (BITS_W),
        .DEPTH (COLUMNS)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.column_bits),
        .rd_addr (col_idx_next[AW-1:0]),
        .rd_data (ram_rd)
    );

    // The RAM read was issued last cycle at the current column; a write to that
    // column in the same cycle is forwarded here.
    always_comb
    begin
        if (wr_last_reg && (wr_addr_last_reg == col_addr))
        begin
            pattern = wr_data_last_reg;
        end
        else if (col_valid_reg[col_addr])
        begin
            pattern = ram_rd;
        end
        else
        begin
            pattern = picture_column(8'(col_addr));
        end
    end

    always_comb
    begin
        tick_next    = tick_reg;
        cmp_next     = cmp_reg;
        step_next    = step_reg;
        sub_next     = sub_reg;
        quot_next    = quot_reg;
        col_idx_next = col_idx_reg;
        led_next     = led_reg;
        strobe_next  = strobe_reg;
        match        = 1'b0;
        if (accept)
        begin
            strobe_next = 1'b0;
            case (item.mode)
                MODE_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                    if (sub_reg == SW'(COLUMNS - 1))
                    begin
                        sub_next = '0;
                        if (quot_reg != '1)
                        begin
                            quot_next = quot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                    if (tick_next == cmp_reg)
                    begin
                        match       = 1'b1;
                        led_next    = col_lt ? pattern : '0;
                        strobe_next = 1'b1;
                        cmp_next    = tick_next + TW'(step_reg);
                        if (col_lt)
                        begin
                            col_idx_next = col_idx_reg + 1'b1;
                        end
                    end
                end
                MODE_HALL:
                begin
                    step_next    = quot_reg;
                    cmp_next     = TW'(quot_reg);
                    tick_next    = '0;
                    sub_next     = '0;
                    quot_next    = '0;
                    col_idx_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            cmp_reg       <= '0;
            step_reg      <= '0;
            sub_reg       <= '0;
            quot_reg      <= '0;
            col_idx_reg   <= CIW'(COLUMNS);
            led_reg       <= '0;
            strobe_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            col_valid_reg <= '0;
            wr_last_reg   <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            cmp_reg       <= cmp_next;
            step_reg      <= step_next;
            sub_reg       <= sub_next;
            quot_reg      <= quot_next;
            col_idx_reg   <= col_idx_next;
            led_reg       <= led_next;
            strobe_reg    <= strobe_next;
            out_valid_reg <= out_valid_next;
            wr_last_reg   <= wr_en;
            if (wr_en)
            begin
                col_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_last_reg <= wr_addr;
        wr_data_last_reg <= item.column_bits;
    end

    assign item.ready           = !out_valid_reg || result.ready;
    assign result.valid         = out_valid_reg;
    assign result.led_drive     = led_reg;
    assign result.column_strobe = strobe_reg;
    assign result.column_shown  = SHOWN_W'(col_idx_reg);

    `PCTC_ASSERT_NEXT(a_hall_restart, hall_acc, col_idx_reg == '0 && tick_reg == '0)
    `PCTC_ASSERT_NEXT(a_match_advance, match, col_idx_reg == CIW'(COLUMNS) || col_idx_reg == $past(col_idx_reg) + 1'b1)
    `PCTC_ASSERT_NEXT(a_blank_past_end, match && !col_lt, led_reg == '0 && strobe_reg)
    `PCTC_ASSERT_SAME(a_no_accept_when_full, out_valid_reg && !result.ready, !accept)

endmodule

// ===== src/pctc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
